[hw/rtl/depth_scan_to_point_cloud_assert.svh]
// ---------------------------------------------------------------------------
// depth_scan_to_point_cloud assertion macros
// Shorthand for the concurrent checks of the point cloud converter. Every
// check is clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DEPTH_SCAN_TO_POINT_CLOUD_ASSERT_SVH
`define DEPTH_SCAN_TO_POINT_CLOUD_ASSERT_SVH

// The expression holds at every clock edge.
`define DSPC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define DSPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define DSPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dspc_pkg.sv]
// ===========================================================================
// dspc_pkg
// Types, constants and helper functions shared by the depth scan to point
// cloud converter.
// ===========================================================================
`default_nettype none

package dspc_pkg;

    // Scan geometry limits and angle resolution.
    localparam int MAX_YAW    = 1024;
    localparam int MAX_PITCH  = 1024;
    localparam int ANGLE_BITS = 16;

    // Field widths.
    localparam int COUNT_W   = 11;
    localparam int ANGLE_W   = 16;
    localparam int RANGE_W   = 32;
    localparam int COORD_W   = 33;
    localparam int TOTAL_W   = 21;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;

    // Grid position widths.
    localparam int YAW_POS_W   = (MAX_YAW > 1) ? $clog2(MAX_YAW) : 1;
    localparam int PITCH_POS_W = (MAX_PITCH > 1) ? $clog2(MAX_PITCH) : 1;
    localparam int POS_MAX_W   = (YAW_POS_W > PITCH_POS_W) ? YAW_POS_W : PITCH_POS_W;
    localparam int CMP_W       = ((COUNT_W > POS_MAX_W) ? COUNT_W : POS_MAX_W) + 2;
    localparam int SUM_W       = ANGLE_W + POS_MAX_W + 1;

    // Rotation datapath.
    localparam int GUARD_BITS   = 16;
    localparam int CORDIC_STEPS = 32;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int TURN_W       = 32;
    localparam int ATAN_W       = 30;
    localparam int MAG_W        = 50;
    localparam int HALF_W       = MAG_W / 2;
    localparam int KINV_W       = 32;
    localparam int PROD_W       = HALF_W + KINV_W;
    localparam int ACC_W        = MAG_W + KINV_W;
    localparam int VEC_W        = MAG_W + 2;
    localparam int ZW           = TURN_W + 2;

    // Reciprocal of the rotation gain, scaled by 2^32.
    localparam logic [KINV_W-1:0] KINV = 32'd2608131496;

    // Saturation bounds of a coordinate, held at the vector width.
    localparam logic signed [VEC_W-1:0] COORD_HI =
        {{(VEC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [VEC_W-1:0] COORD_LO =
        {{(VEC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CLS_VALID = 2'd0,
        CLS_CLOSE = 2'd1,
        CLS_FAR   = 2'd2,
        CLS_ERROR = 2'd3
    } class_t;

    typedef enum logic [2:0] {
        REG_YAW_COUNT   = 3'd0,
        REG_PITCH_COUNT = 3'd1,
        REG_YAW_START   = 3'd2,
        REG_YAW_STEP    = 3'd3,
        REG_PITCH_START = 3'd4,
        REG_PITCH_STEP  = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_FIN,
        ST_ROT,
        ST_SWAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] yaw_count;
        logic [COUNT_W-1:0] pitch_count;
        logic [ANGLE_W-1:0] yaw_start;
        logic [ANGLE_W-1:0] yaw_step;
        logic [ANGLE_W-1:0] pitch_start;
        logic [ANGLE_W-1:0] pitch_step;
    } dspc_cfg_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] a;
        begin
            case (i)
                5'd0:  a = 30'd536870912;
                5'd1:  a = 30'd316933406;
                5'd2:  a = 30'd167458907;
                5'd3:  a = 30'd85004756;
                5'd4:  a = 30'd42667331;
                5'd5:  a = 30'd21354465;
                5'd6:  a = 30'd10679838;
                5'd7:  a = 30'd5340245;
                5'd8:  a = 30'd2670163;
                5'd9:  a = 30'd1335087;
                5'd10: a = 30'd667544;
                5'd11: a = 30'd333772;
                5'd12: a = 30'd166886;
                5'd13: a = 30'd83443;
                5'd14: a = 30'd41722;
                5'd15: a = 30'd20861;
                5'd16: a = 30'd10430;
                5'd17: a = 30'd5215;
                5'd18: a = 30'd2608;
                5'd19: a = 30'd1304;
                5'd20: a = 30'd652;
                5'd21: a = 30'd326;
                5'd22: a = 30'd163;
                5'd23: a = 30'd81;
                5'd24: a = 30'd41;
                5'd25: a = 30'd20;
                5'd26: a = 30'd10;
                5'd27: a = 30'd5;
                5'd28: a = 30'd3;
                5'd29: a = 30'd1;
                5'd30: a = 30'd1;
                default: a = 30'd0;
            endcase
            return a;
        end
    endfunction

    // Drops the guard bits with rounding and saturates to the coordinate range.
    function automatic logic signed [COORD_W-1:0] finish_coord(
        input logic signed [VEC_W-1:0] v
    );
        logic signed [VEC_W-1:0] r;
        logic signed [VEC_W-1:0] half;
        begin
            half = $signed(VEC_W'(1) << (GUARD_BITS - 1));
            r    = (v + half) >>> GUARD_BITS;
            if (r > COORD_HI) begin
                r = COORD_HI;
            end
            else if (r < COORD_LO) begin
                r = COORD_LO;
            end
            return r[COORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/dspc_if.sv]
// ===========================================================================
// dspc_if
// Valid/ready channels of the point cloud converter: range readings in,
// Cartesian points out.
// ===========================================================================
`default_nettype none

interface dspc_range_if
    import dspc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_reading;
    logic               error_flag;

    modport source (output valid, output range_reading, output error_flag, input ready);
    modport sink   (input valid, input range_reading, input error_flag, output ready);
endinterface

interface dspc_point_if
    import dspc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      point_valid;
    logic [1:0]                reading_class;
    logic [TOTAL_W-1:0]        valid_total;
    logic                      frame_end;

    modport source (
        output valid, output pos_x, output pos_y, output pos_z, output point_valid,
        output reading_class, output valid_total, output frame_end, input ready
    );
    modport sink (
        input valid, input pos_x, input pos_y, input pos_z, input point_valid,
        input reading_class, input valid_total, input frame_end, output ready
    );
endinterface

`default_nettype wire

[hw/rtl/depth_scan_to_point_cloud.sv]
// ===========================================================================
// depth_scan_to_point_cloud
// Converts a depth scan, one range reading per transaction, into Cartesian
// points using one shared scaling multiplier and one shared rotation stage.
// ===========================================================================
//
// Usage:
// Range readings arrive on the readings channel in scan order, yaw outer and
// pitch inner; the block keeps the grid position itself. Every reading yields
// exactly one transaction on the points channel, carrying the coordinates
// (zero unless the reading is valid), the reading class, the running count of
// valid points in the scan and a frame end mark on the last grid cell.
// A valid reading passes two gain scalings, each a low half, high half and
// finish step on a single 25 by 32 bit multiplier, two rotations of 32
// iterations each on one shift-add stage, a swap step and an output step;
// any other reading goes straight to the output step. No new reading is
// accepted until the result is loaded; the next one can be accepted in the
// cycle after. The result sits in an output register, so a stalled receiver
// only holds the block once it has finished the following reading.
// Reset returns the geometry registers to their defaults, the grid position
// and the valid count to zero, and drops any pending result.
// Geometry must be written over APB only while the block is idle, which the
// block does not enforce itself; a write does not move the grid position.
//
`default_nettype none

module depth_scan_to_point_cloud
    import dspc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    dspc_range_if.sink        readings,
    dspc_point_if.source      points,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // -----------------------------------------------------------------------
    // Configuration registers.
    // -----------------------------------------------------------------------
    dspc_cfg_t cfg;

    dspc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // -----------------------------------------------------------------------
    // Sequencer and datapath registers.
    // -----------------------------------------------------------------------
    state_t                     state_reg, state_next;
    class_t                     cls_reg, cls_next;
    logic                       phase_reg, phase_next;     // 0 pitch pass, 1 yaw pass
    logic                       sign_reg, sign_next;
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [TURN_W-1:0]          ang_reg, ang_next;
    logic signed [VEC_W-1:0]    x_reg, x_next;
    logic signed [VEC_W-1:0]    y_reg, y_next;
    logic signed [ZW-1:0]       z_reg, z_next;
    logic signed [VEC_W-1:0]    cz_reg, cz_next;
    logic [STEP_W-1:0]          iter_reg, iter_next;

    // Scan position state.
    logic [YAW_POS_W-1:0]       yaw_pos_reg, yaw_pos_next;
    logic [PITCH_POS_W-1:0]     pitch_pos_reg, pitch_pos_next;
    logic [TOTAL_W-1:0]         valid_cnt_reg, valid_cnt_next;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0]  out_x_reg, out_x_next;
    logic signed [COORD_W-1:0]  out_y_reg, out_y_next;
    logic signed [COORD_W-1:0]  out_z_reg, out_z_next;
    class_t                     out_cls_reg, out_cls_next;
    logic [TOTAL_W-1:0]         out_total_reg, out_total_next;
    logic                       out_fend_reg, out_fend_next;

    // -----------------------------------------------------------------------
    // Combinational helpers.
    // -----------------------------------------------------------------------
    logic                       in_accept;
    logic                       out_load;
    class_t                     in_cls;
    logic [HALF_W-1:0]          mul_a;
    logic [PROD_W-1:0]          prod;
    logic [SUM_W-1:0]           ang_idx;
    logic [SUM_W-1:0]           ang_start;
    logic [SUM_W-1:0]           ang_step;
    logic [SUM_W-1:0]           ang_sum;
    logic [TURN_W-1:0]          ang_turn;
    logic [TURN_W-1:0]          ang_quarter;
    logic                       ang_flip;
    logic [MAG_W-1:0]           scaled;
    logic signed [VEC_W-1:0]    scaled_s;
    logic signed [VEC_W-1:0]    dx, dy;
    logic signed [ZW-1:0]       atan_s;
    logic                       z_pos;
    logic [CMP_W-1:0]           yaw_eff, pitch_eff;
    logic                       last_p, last_y, fend;
    logic [TOTAL_W-1:0]         cnt_inc;

    assign readings.ready = (state_reg == ST_IDLE);
    assign in_accept      = readings.valid && readings.ready;
    assign out_load       = (state_reg == ST_DONE) && (!out_valid_reg || points.ready);

    // Classification: the error flag wins over both distance codes.
    always_comb
    begin
        if (readings.error_flag)
        begin
            in_cls = CLS_ERROR;
        end
        else if (readings.range_reading == '0)
        begin
            in_cls = CLS_CLOSE;
        end
        else if (readings.range_reading == '1)
        begin
            in_cls = CLS_FAR;
        end
        else
        begin
            in_cls = CLS_VALID;
        end
    end

    // The shared multiplier handles the magnitude in two halves, low half first.
    assign mul_a = (state_reg == ST_MUL_LO) ? mag_reg[HALF_W-1:0] : mag_reg[MAG_W-1:HALF_W];
    assign prod  = PROD_W'(mul_a) * PROD_W'(KINV);

    // Angle of the current grid cell, widened to a 32-bit turn.
    assign ang_idx   = phase_reg ? SUM_W'(yaw_pos_reg) : SUM_W'(pitch_pos_reg);
    assign ang_start = phase_reg ? SUM_W'(cfg.yaw_start) : SUM_W'(cfg.pitch_start);
    assign ang_step  = phase_reg ? SUM_W'(cfg.yaw_step) : SUM_W'(cfg.pitch_step);
    assign ang_sum   = ang_start + ang_idx * ang_step;
    assign ang_turn  = TURN_W'(ang_sum[ANGLE_BITS-1:0]) << (TURN_W - ANGLE_BITS);

    // Angles in the left half-plane: negate the vector and add half a turn.
    assign ang_quarter = ang_reg + (TURN_W'(1) << (TURN_W - 2));
    assign ang_flip    = ang_quarter[TURN_W-1];
    assign scaled      = acc_reg[ACC_W-1:KINV_W];
    assign scaled_s    = $signed(VEC_W'(scaled));

    // One rotation iteration.
    assign dx     = y_reg >>> iter_reg;
    assign dy     = x_reg >>> iter_reg;
    assign atan_s = $signed(ZW'(atan_entry(iter_reg)));
    assign z_pos  = !z_reg[ZW-1];

    // Scan bookkeeping: a zero count acts as one, an oversize count as the maximum.
    always_comb
    begin
        if (cfg.yaw_count == '0)
        begin
            yaw_eff = CMP_W'(1);
        end
        else if (CMP_W'(cfg.yaw_count) > CMP_W'(MAX_YAW))
        begin
            yaw_eff = CMP_W'(MAX_YAW);
        end
        else
        begin
            yaw_eff = CMP_W'(cfg.yaw_count);
        end

        if (cfg.pitch_count == '0)
        begin
            pitch_eff = CMP_W'(1);
        end
        else if (CMP_W'(cfg.pitch_count) > CMP_W'(MAX_PITCH))
        begin
            pitch_eff = CMP_W'(MAX_PITCH);
        end
        else
        begin
            pitch_eff = CMP_W'(cfg.pitch_count);
        end
    end

    // A position at or beyond the count is treated as the last one.
    assign last_p  = (CMP_W'(pitch_pos_reg) + CMP_W'(1)) >= pitch_eff;
    assign last_y  = (CMP_W'(yaw_pos_reg) + CMP_W'(1)) >= yaw_eff;
    assign fend    = last_p && last_y;
    assign cnt_inc = (cls_reg == CLS_VALID) ? valid_cnt_reg + TOTAL_W'(1) : valid_cnt_reg;

    // -----------------------------------------------------------------------
    // Next state and datapath control.
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cls_next       = cls_reg;
        phase_next     = phase_reg;
        sign_next      = sign_reg;
        mag_next       = mag_reg;
        acc_next       = acc_reg;
        ang_next       = ang_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        cz_next        = cz_reg;
        iter_next      = iter_reg;
        yaw_pos_next   = yaw_pos_reg;
        pitch_pos_next = pitch_pos_reg;
        valid_cnt_next = valid_cnt_reg;
        out_valid_next = out_valid_reg && !points.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_cls_next   = out_cls_reg;
        out_total_next = out_total_reg;
        out_fend_next  = out_fend_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cls_next   = in_cls;
                    phase_next = 1'b0;
                    sign_next  = 1'b0;
                    // Distance widened by the guard bits.
                    mag_next   = MAG_W'({readings.range_reading, {GUARD_BITS{1'b0}}});
                    state_next = (in_cls == CLS_VALID) ? ST_MUL_LO : ST_DONE;
                end
            end

            ST_MUL_LO:
            begin
                // Rounding constant folded into the first partial product.
                acc_next   = (ACC_W'(1) << (KINV_W - 1)) + ACC_W'(prod);
                ang_next   = ang_turn;
                state_next = ST_MUL_HI;
            end

            ST_MUL_HI:
            begin
                acc_next   = acc_reg + (ACC_W'(prod) << HALF_W);
                state_next = ST_MUL_FIN;
            end

            ST_MUL_FIN:
            begin
                x_next     = (sign_reg ^ ang_flip) ? -scaled_s : scaled_s;
                y_next     = '0;
                z_next     = ang_flip ? $signed(ZW'($signed(ang_reg + (TURN_W'(1) << (TURN_W - 1)))))
                                      : $signed(ZW'($signed(ang_reg)));
                iter_next  = '0;
                state_next = ST_ROT;
            end

            ST_ROT:
            begin
                if (z_pos)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_s;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_s;
                end
                iter_next = iter_reg + STEP_W'(1);
                if (iter_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = phase_reg ? ST_DONE : ST_SWAP;
                end
            end

            ST_SWAP:
            begin
                // Keep z from the pitch pass and rescale the horizontal length.
                cz_next    = y_reg;
                sign_next  = x_reg[VEC_W-1];
                mag_next   = x_reg[VEC_W-1] ? MAG_W'(-x_reg) : MAG_W'(x_reg);
                phase_next = 1'b1;
                state_next = ST_MUL_LO;
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (cls_reg == CLS_VALID)
                    begin
                        out_x_next = finish_coord(x_reg);
                        out_y_next = finish_coord(y_reg);
                        out_z_next = finish_coord(cz_reg);
                    end
                    else
                    begin
                        out_x_next = '0;
                        out_y_next = '0;
                        out_z_next = '0;
                    end
                    out_cls_next   = cls_reg;
                    out_total_next = cnt_inc;
                    out_fend_next  = fend;

                    if (!last_p)
                    begin
                        pitch_pos_next = pitch_pos_reg + PITCH_POS_W'(1);
                    end
                    else
                    begin
                        pitch_pos_next = '0;
                        yaw_pos_next   = last_y ? '0 : yaw_pos_reg + YAW_POS_W'(1);
                    end
                    valid_cnt_next = fend ? '0 : cnt_inc;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Registers.
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            phase_reg     <= 1'b0;
            yaw_pos_reg   <= '0;
            pitch_pos_reg <= '0;
            valid_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            phase_reg     <= phase_next;
            yaw_pos_reg   <= yaw_pos_next;
            pitch_pos_reg <= pitch_pos_next;
            valid_cnt_reg <= valid_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg       <= cls_next;
        sign_reg      <= sign_next;
        mag_reg       <= mag_next;
        acc_reg       <= acc_next;
        ang_reg       <= ang_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        cz_reg        <= cz_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_z_reg     <= out_z_next;
        out_cls_reg   <= out_cls_next;
        out_total_reg <= out_total_next;
        out_fend_reg  <= out_fend_next;
    end

    // -----------------------------------------------------------------------
    // Result channel.
    // -----------------------------------------------------------------------
    assign points.valid         = out_valid_reg;
    assign points.pos_x         = out_x_reg;
    assign points.pos_y         = out_y_reg;
    assign points.pos_z         = out_z_reg;
    assign points.point_valid   = (out_cls_reg == CLS_VALID);
    assign points.reading_class = out_cls_reg;
    assign points.valid_total   = out_total_reg;
    assign points.frame_end     = out_fend_reg;

    // -----------------------------------------------------------------------
    // Assertions.
    // -----------------------------------------------------------------------
`include "depth_scan_to_point_cloud_assert.svh"

    // A reading that gave no point carries zero coordinates.
    `DSPC_ASSERT_SAME(a_invalid_zero, points.valid && !points.point_valid,
        (points.pos_x == '0) && (points.pos_y == '0) && (points.pos_z == '0),
        "non-valid reading with nonzero coordinates")

    // Closing a frame returns the grid position and the valid count to zero.
    `DSPC_ASSERT_NEXT(a_frame_wrap, out_load && fend,
        (yaw_pos_reg == '0) && (pitch_pos_reg == '0) && (valid_cnt_reg == '0),
        "scan state not cleared after frame end")

    // The rotation counter only runs inside a rotation pass.
    `DSPC_ASSERT_SAME(a_iter_idle, state_reg != ST_ROT && state_reg != ST_MUL_FIN,
        iter_reg == '0, "rotation counter running outside a rotation")

endmodule

`default_nettype wire

[hw/rtl/dspc_regs.sv]
// ===========================================================================
// dspc_regs
// APB register file holding the scan geometry: counts, start angles and
// angle steps.
// ===========================================================================
`default_nettype none

module dspc_regs
    import dspc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output dspc_cfg_t         cfg
);

    dspc_cfg_t cfg_reg;
    reg_idx_t  idx;
    logic      wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.yaw_count   <= COUNT_W'(1024);
            cfg_reg.pitch_count <= COUNT_W'(1);
            cfg_reg.yaw_start   <= '0;
            cfg_reg.yaw_step    <= ANGLE_W'(64);
            cfg_reg.pitch_start <= '0;
            cfg_reg.pitch_step  <= ANGLE_W'(64);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_YAW_COUNT:   cfg_reg.yaw_count   <= pwdata[COUNT_W-1:0];
                REG_PITCH_COUNT: cfg_reg.pitch_count <= pwdata[COUNT_W-1:0];
                REG_YAW_START:   cfg_reg.yaw_start   <= pwdata[ANGLE_W-1:0];
                REG_YAW_STEP:    cfg_reg.yaw_step    <= pwdata[ANGLE_W-1:0];
                REG_PITCH_START: cfg_reg.pitch_start <= pwdata[ANGLE_W-1:0];
                REG_PITCH_STEP:  cfg_reg.pitch_step  <= pwdata[ANGLE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_YAW_COUNT:   prdata = DATA_W'(cfg_reg.yaw_count);
            REG_PITCH_COUNT: prdata = DATA_W'(cfg_reg.pitch_count);
            REG_YAW_START:   prdata = DATA_W'(cfg_reg.yaw_start);
            REG_YAW_STEP:    prdata = DATA_W'(cfg_reg.yaw_step);
            REG_PITCH_START: prdata = DATA_W'(cfg_reg.pitch_start);
            REG_PITCH_STEP:  prdata = DATA_W'(cfg_reg.pitch_step);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire
